// ===== rtl/core/epoch_seconds_to_civil_date_defines.svh =====
// Assertion macros used by the civil date converter top level.
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ESC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESC_ASSERT(label, prop, msg)
`define ESC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/esc_pkg.sv =====
// Shared widths, constants, microcode types and program ROM for the date converter.
package esc_pkg;

  localparam int SECONDS_W = 32;
  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int DAYS_W    = 16;   // whole days since epoch, at most 49710
  localparam int LEN_W     = 9;    // a year or month length in days

  localparam int SECONDS_PER_DAY = 86400;
  localparam int FIRST_YEAR      = 1970;

  // Whole days by reciprocal multiply: seconds per day is 675 shifted left by 7,
  // and ceil(2^35 / 675) gives the exact quotient for every 25-bit operand.
  localparam int DAY_SHIFT   = 7;
  localparam int DAY_ODD     = SECONDS_PER_DAY >> DAY_SHIFT;
  localparam int QUOT_W      = SECONDS_W - DAY_SHIFT;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 26;
  localparam int PROD_W      = QUOT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DAY_RECIP =
      RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(DAY_ODD) - 1) / longint'(DAY_ODD));

  // Year residues kept alongside the year, seeded for the first year.
  localparam int Y100_W = 7;
  localparam int Y400_W = 9;
  localparam logic [1:0]        FIRST_Y4   = 2'(FIRST_YEAR % 4);
  localparam logic [Y100_W-1:0] FIRST_Y100 = Y100_W'(FIRST_YEAR % 100);
  localparam logic [Y400_W-1:0] FIRST_Y400 = Y400_W'(FIRST_YEAR % 400);
  localparam logic [Y100_W-1:0] Y100_LAST  = Y100_W'(99);
  localparam logic [Y400_W-1:0] Y400_LAST  = Y400_W'(399);

  localparam logic [LEN_W-1:0] COMMON_YEAR_LEN = LEN_W'(365);
  localparam logic [LEN_W-1:0] LEAP_YEAR_LEN   = LEN_W'(366);

  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(11);

  // Program counter and step addresses.
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_YEAR  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_MONTH = PC_W'(3);
  localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_BACK  = PC_W'(5);

  // Datapath operation selected by a control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  // Jump condition of a control word; a false condition falls through.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_NO_START,
    COND_YEAR_MORE,
    COND_MONTH_MORE,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic start;
    logic year_more;
    logic month_more;
    logic out_busy;
  } status_t;

  // Days in each month of a common year, January first.
  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [LEN_W-1:0] len;
    case (m)
      4'd1:    len = LEN_W'(28);
      4'd3:    len = LEN_W'(30);
      4'd5:    len = LEN_W'(30);
      4'd8:    len = LEN_W'(30);
      4'd10:   len = LEN_W'(30);
      default: len = LEN_W'(31);
    endcase
    return len;
  endfunction

  // Control program: load, divide, walk years, walk months, emit, return.
  function automatic ctrl_t micro_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_NO_START,   target: PC_LOAD};
      PC_DIV:   w = '{op: OP_DIV,   cond: COND_NEXT,       target: PC_YEAR};
      PC_YEAR:  w = '{op: OP_YEAR,  cond: COND_YEAR_MORE,  target: PC_YEAR};
      PC_MONTH: w = '{op: OP_MONTH, cond: COND_MONTH_MORE, target: PC_MONTH};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,   target: PC_EMIT};
      PC_BACK:  w = '{op: OP_NOP,   cond: COND_ALWAYS,     target: PC_LOAD};
      default:  w = '{op: OP_NOP,   cond: COND_ALWAYS,     target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/esc_in_if.sv =====
// Input channel: one epoch seconds word per handshake.
interface esc_in_if;
  import esc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SECONDS_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== rtl/core/esc_out_if.sv =====
// Output channel: one calendar date word per handshake.
interface esc_out_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_number;
  logic [MONTH_W-1:0] month_number;
  logic [DAY_W-1:0]   day_of_month;

  modport source (output valid, output year_number, output month_number,
                  output day_of_month, input ready);
  modport sink   (input valid, input year_number, input month_number,
                  input day_of_month, output ready);
endinterface

// ===== rtl/core/esc_sequencer.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module esc_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  esc_pkg::status_t      status,
  output esc_pkg::ctrl_t        ctrl,
  output logic [esc_pkg::PC_W-1:0] pc
);
  import esc_pkg::*;

  logic            jump;
  logic [PC_W-1:0] pc_next;

  // Fetch the control word of the current step.
  assign ctrl = micro_rom(pc);

  // Evaluate the jump condition.
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:       jump = 1'b0;
      COND_NO_START:   jump = !status.start;
      COND_YEAR_MORE:  jump = status.year_more;
      COND_MONTH_MORE: jump = status.month_more;
      COND_OUT_BUSY:   jump = status.out_busy;
      COND_ALWAYS:     jump = 1'b1;
      default:         jump = 1'b1;
    endcase
  end

  assign pc_next = jump ? ctrl.target : pc + PC_W'(1);

  // Advance the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end
endmodule

// ===== rtl/core/esc_datapath.sv =====
// Datapath: reciprocal divide by seconds per day, year and month walk, output register.
module esc_datapath (
  input  logic             clk,
  input  logic             rst,
  input  esc_pkg::ctrl_t   ctrl,
  output esc_pkg::status_t status,
  esc_in_if.sink           seconds_in,
  esc_out_if.source        date_out
);
  import esc_pkg::*;

  logic [SECONDS_W-1:0] secs;
  logic [DAYS_W-1:0]    days;
  logic [YEAR_W-1:0]    year;
  logic [1:0]           y4;
  logic [Y100_W-1:0]    y100;
  logic [Y400_W-1:0]    y400;
  logic [MONTH_W-1:0]   month;
  logic                 out_valid;

  logic                 leap;
  logic [PROD_W-1:0]    day_prod;
  logic [LEN_W-1:0]     year_len;
  logic [LEN_W-1:0]     mon_len;
  logic                 start;
  logic                 out_busy;

  // Leap year from the tracked residues.
  assign leap     = (y400 == '0) || ((y4 == 2'd0) && (y100 != '0));
  assign year_len = leap ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
  assign mon_len  = month_len(month)
                  + LEN_W'((month == MONTH_FEB) && leap);

  // Whole days: drop the power-of-two factor, then multiply by the reciprocal of 675.
  assign day_prod = PROD_W'(secs[SECONDS_W-1:DAY_SHIFT]) * PROD_W'(DAY_RECIP);

  // Handshake on both channels.
  assign seconds_in.ready = (ctrl.op == OP_LOAD);
  assign start            = seconds_in.valid && seconds_in.ready;
  assign out_busy         = out_valid && !date_out.ready;
  assign date_out.valid   = out_valid;

  // Report branch flags.
  always_comb begin
    status.start      = start;
    status.year_more  = ({{(DAYS_W-LEN_W){1'b0}}, year_len} <= days);
    status.month_more = (month != MONTH_LAST)
                     && ({{(DAYS_W-LEN_W){1'b0}}, mon_len} <= days);
    status.out_busy   = out_busy;
  end

  // Work registers, one operation per step.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (start) begin
          secs    <= seconds_in.epoch_seconds;
          year    <= YEAR_W'(FIRST_YEAR);
          y4      <= FIRST_Y4;
          y100    <= FIRST_Y100;
          y400    <= FIRST_Y400;
          month   <= '0;
        end
      end
      OP_DIV: begin
        days <= day_prod[RECIP_SHIFT +: DAYS_W];
      end
      OP_YEAR: begin
        if (status.year_more) begin
          days <= days - {{(DAYS_W-LEN_W){1'b0}}, year_len};
          year <= year + YEAR_W'(1);
          y4   <= y4 + 2'd1;
          y100 <= (y100 == Y100_LAST) ? '0 : y100 + Y100_W'(1);
          y400 <= (y400 == Y400_LAST) ? '0 : y400 + Y400_W'(1);
        end
      end
      OP_MONTH: begin
        if (status.month_more) begin
          days  <= days - {{(DAYS_W-LEN_W){1'b0}}, mon_len};
          month <= month + MONTH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output word: load on emit when the slot is free, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (date_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      date_out.year_number  <= year;
      date_out.month_number <= month + MONTH_W'(1);
      date_out.day_of_month <= days[DAY_W-1:0] + DAY_W'(1);
    end
  end
endmodule

// ===== rtl/core/epoch_seconds_to_civil_date.sv =====
// Top level: converts a seconds-since-1970 count to a Gregorian calendar date.
//
//   Channel     Dir  Word                                    Take
//   seconds_in  in   epoch_seconds[31:0]                     valid && ready
//   date_out    out  year_number[11:0] month_number[3:0]     valid && ready
//                    day_of_month[4:0]
//
// An item passes through the load and divide steps, a year walk and a month walk
// that repeat their step while a whole year or month remains, then the emit and
// return steps of the microcoded sequencer.
// Reset (rst, synchronous) returns the sequencer to its load step and empties
// the output register. A stalled output holds the sequencer at its emit step;
// the next word is taken while a finished date waits in the output register.
module epoch_seconds_to_civil_date (
  input  logic      clk,
  input  logic      rst,
  esc_in_if.sink    seconds_in,
  esc_out_if.source date_out
);
  import esc_pkg::*;

`include "epoch_seconds_to_civil_date_defines.svh"

  ctrl_t           ctrl;
  status_t         status;
  logic [PC_W-1:0] pc;

  esc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .pc     (pc)
  );

  esc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .status     (status),
    .seconds_in (seconds_in),
    .date_out   (date_out)
  );

  // A taken word starts the divider on the next step.
  `ESC_ASSERT(a_load_to_div, (seconds_in.valid && seconds_in.ready) |=> (pc == PC_DIV), "taken word did not start the divider")
  // A new date appears only out of the emit step.
  `ESC_ASSERT(a_emit_source, $rose(date_out.valid) |-> $past(pc == PC_EMIT), "date raised outside the emit step")
  // A presented month stays within the calendar.
  `ESC_ASSERT(a_month_range, date_out.valid |-> (date_out.month_number >= 4'd1 && date_out.month_number <= 4'd12), "month out of range")
  // Reset empties the output register.
  `ESC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !date_out.valid, "date valid right after reset")
endmodule
